[rtl/wwmr_pkg.sv]
// Shared types and constants of the minimum-raggedness word wrap block.
package wwmr_pkg;
    localparam int WIDTH_W = 12;
    localparam int COST_W = 43;
    localparam int OUT_COST_W = 42;
    localparam int OUT_IDX_W = 6;
    localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};
    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = 12'd80;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_WIDE = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef logic [COST_W-1:0] cost_t;
    typedef logic [WIDTH_W-1:0] width_t;
endpackage

[rtl/word_wrap_min_raggedness.sv]
// Top level of the minimum-raggedness word wrap block.
//
// Words load at one per cycle, unless the input is stalled, into a prefix-sum memory. On
// the final word the block flags an overflow or an over-wide word as an error; else it
// runs the line-break search with one shared multiplier under a sequencer: a candidate
// line start that fits passes memory read, fit check, two multiplies for the cube and
// compare, one that does not fit ends at the fit check, each end word adds a prefix read
// and a cost write, then the backtrack reads one break per line and each line is sent.
// The input is stalled from the final word until the last result is loaded.
module word_wrap_min_raggedness #(
    parameter int MAX_WORDS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wwmr_pkg::WIDTH_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    word_length,
    input  logic                          last_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [5:0]                    first_word,
    output logic [5:0]                    last_word_index,
    output logic                          last_line,
    output logic [1:0]                    status,
    output logic [41:0]                   total_cost
);
    import wwmr_pkg::*;

    localparam int IW = $clog2(MAX_WORDS + 1);
    localparam int LAW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int PW = 8 + IW;
    localparam int UW = (PW + 1 > 13) ? PW + 1 : 13;
    localparam logic [IW-1:0] MAXW = IW'(MAX_WORDS);
    localparam logic [IW-1:0] ONE = IW'(1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_ERR   = 4'd2;
    localparam logic [3:0] S_JRD   = 4'd3;
    localparam logic [3:0] S_JLAT  = 4'd4;
    localparam logic [3:0] S_IRD   = 4'd5;
    localparam logic [3:0] S_ICMP  = 4'd6;
    localparam logic [3:0] S_MUL1  = 4'd7;
    localparam logic [3:0] S_MUL2  = 4'd8;
    localparam logic [3:0] S_UPD   = 4'd9;
    localparam logic [3:0] S_JWR   = 4'd10;
    localparam logic [3:0] S_BTRD  = 4'd11;
    localparam logic [3:0] S_BTLAT = 4'd12;
    localparam logic [3:0] S_ERD   = 4'd13;
    localparam logic [3:0] S_EOUT  = 4'd14;

    logic [3:0] state_reg, state_next;
    width_t lw_reg;
    logic [IW-1:0] count_reg, count_next;
    logic [1:0] err_reg, err_next;
    logic [7:0] maxlen_reg, maxlen_next;
    logic [PW-1:0] psum_reg, psum_next;
    logic [IW-1:0] j_reg, j_next, i_reg, i_next;
    logic [PW-1:0] pj_reg, pj_next;
    cost_t cur_best_reg, cur_best_next, b_reg, b_next, total_reg, total_next;
    logic [IW-1:0] cur_bp_reg, cur_bp_next;
    logic [WIDTH_W-1:0] spare_reg, spare_next;
    logic [35:0] prod_reg, prod_next;
    logic [IW-1:0] lines_reg, lines_next;

    logic ov_reg, ov_next;
    logic [5:0] fw_reg, fw_next, lwi_reg, lwi_next;
    logic ll_reg, ll_next;
    logic [1:0] st_reg, st_next;
    logic [41:0] tc_reg, tc_next;

    logic accept, out_free;
    logic p_we, c_we, l_we;
    logic [IW-1:0] p_waddr, p_raddr, c_raddr, bp_raddr;
    logic [PW-1:0] p_wdata, p_rdata, p_val;
    cost_t c_rdata, b_val;
    logic [IW-1:0] bp_rdata;
    logic [LAW-1:0] l_waddr, l_raddr;
    logic [2*IW-1:0] l_wdata, l_rdata;
    logic [UW-1:0] used;
    logic [23:0] mul_x;
    logic [35:0] mul_p;
    logic [COST_W:0] sum;
    cost_t step_cost;

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;

    assign out_valid = ov_reg;
    assign first_word = fw_reg;
    assign last_word_index = lwi_reg;
    assign last_line = ll_reg;
    assign status = st_reg;
    assign total_cost = tc_reg;

    wwmr_ram #(.WIDTH(PW), .DEPTH(MAX_WORDS + 1), .AW(IW)) u_prefix (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );
    wwmr_ram #(.WIDTH(COST_W), .DEPTH(MAX_WORDS + 1), .AW(IW)) u_cost (
        .clk(clk), .we(c_we), .waddr(j_reg), .wdata(cur_best_reg),
        .raddr(c_raddr), .rdata(c_rdata)
    );
    wwmr_ram #(.WIDTH(IW), .DEPTH(MAX_WORDS + 1), .AW(IW)) u_break (
        .clk(clk), .we(c_we), .waddr(j_reg), .wdata(cur_bp_reg),
        .raddr(bp_raddr), .rdata(bp_rdata)
    );
    wwmr_ram #(.WIDTH(2 * IW), .DEPTH(MAX_WORDS), .AW(LAW)) u_lines (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    assign p_we = accept && (count_reg != MAXW);
    assign p_waddr = count_reg + ONE;
    assign p_wdata = psum_reg + PW'(word_length);
    assign p_raddr = (state_reg == S_JRD) ? j_reg : i_reg - ONE;
    assign c_raddr = i_reg - ONE;
    assign bp_raddr = j_reg;
    assign c_we = (state_reg == S_JWR);
    assign l_we = (state_reg == S_BTLAT);
    assign l_waddr = LAW'(lines_reg);
    assign l_wdata = {bp_rdata - ONE, j_reg - ONE};
    assign l_raddr = LAW'(lines_reg - ONE);

    assign p_val = (i_reg == ONE) ? '0 : p_rdata;
    assign b_val = (i_reg == ONE) ? '0 : c_rdata;
    assign used = UW'(pj_reg) - UW'(p_val) + UW'(j_reg - i_reg);
    assign mul_x = (state_reg == S_MUL1) ? 24'(spare_reg) : prod_reg[23:0];
    assign mul_p = mul_x * 36'(spare_reg);
    assign step_cost = (j_reg == count_reg) ? '0 : COST_W'(prod_reg);
    assign sum = {1'b0, b_reg} + {1'b0, step_cost};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        err_next = err_reg;
        maxlen_next = maxlen_reg;
        psum_next = psum_reg;
        j_next = j_reg;
        i_next = i_reg;
        pj_next = pj_reg;
        cur_best_next = cur_best_reg;
        cur_bp_next = cur_bp_reg;
        b_next = b_reg;
        total_next = total_reg;
        spare_next = spare_reg;
        prod_next = prod_reg;
        lines_next = lines_reg;
        ov_next = ov_reg && out_stall;
        fw_next = fw_reg;
        lwi_next = lwi_reg;
        ll_next = ll_reg;
        st_next = st_reg;
        tc_next = tc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg != MAXW)
                    begin
                        count_next = count_reg + ONE;
                        psum_next = p_wdata;
                        if (word_length > maxlen_reg)
                        begin
                            maxlen_next = word_length;
                        end
                    end
                    else
                    begin
                        err_next = STATUS_OVERFLOW;
                    end
                    if (last_word)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (err_reg == STATUS_OK && 12'(maxlen_reg) > lw_reg)
                begin
                    err_next = STATUS_WIDE;
                end
                if (err_reg != STATUS_OK || 12'(maxlen_reg) > lw_reg)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    j_next = ONE;
                    state_next = S_JRD;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    fw_next = '0;
                    lwi_next = '0;
                    ll_next = 1'b1;
                    st_next = err_reg;
                    tc_next = '0;
                    state_next = S_IDLE;
                    count_next = '0;
                    err_next = STATUS_OK;
                    maxlen_next = '0;
                    psum_next = '0;
                end
            end
            S_JRD:
            begin
                state_next = S_JLAT;
            end
            S_JLAT:
            begin
                pj_next = p_rdata;
                i_next = ONE;
                cur_best_next = COST_INF;
                cur_bp_next = '0;
                state_next = S_IRD;
            end
            S_IRD:
            begin
                state_next = S_ICMP;
            end
            S_ICMP:
            begin
                b_next = b_val;
                spare_next = lw_reg - used[WIDTH_W-1:0];
                if (used > UW'(lw_reg) || b_val == COST_INF)
                begin
                    if (i_reg == j_reg)
                    begin
                        state_next = S_JWR;
                    end
                    else
                    begin
                        i_next = i_reg + ONE;
                        state_next = S_IRD;
                    end
                end
                else
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                prod_next = mul_p;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                prod_next = mul_p;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (sum < {1'b0, cur_best_reg})
                begin
                    cur_best_next = sum[COST_W-1:0];
                    cur_bp_next = i_reg;
                end
                if (i_reg == j_reg)
                begin
                    state_next = S_JWR;
                end
                else
                begin
                    i_next = i_reg + ONE;
                    state_next = S_IRD;
                end
            end
            S_JWR:
            begin
                if (j_reg == count_reg)
                begin
                    total_next = cur_best_reg;
                    lines_next = '0;
                    state_next = S_BTRD;
                end
                else
                begin
                    j_next = j_reg + ONE;
                    state_next = S_JRD;
                end
            end
            S_BTRD:
            begin
                state_next = S_BTLAT;
            end
            S_BTLAT:
            begin
                lines_next = lines_reg + ONE;
                j_next = bp_rdata - ONE;
                if (bp_rdata == ONE)
                begin
                    state_next = S_ERD;
                end
                else
                begin
                    state_next = S_BTRD;
                end
            end
            S_ERD:
            begin
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    fw_next = 6'(l_rdata[2*IW-1:IW]);
                    lwi_next = 6'(l_rdata[IW-1:0]);
                    ll_next = (lines_reg == ONE);
                    st_next = STATUS_OK;
                    tc_next = total_reg[OUT_COST_W-1:0];
                    lines_next = lines_reg - ONE;
                    if (lines_reg == ONE)
                    begin
                        state_next = S_IDLE;
                        count_next = '0;
                        err_next = STATUS_OK;
                        maxlen_next = '0;
                        psum_next = '0;
                    end
                    else
                    begin
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lw_reg <= LINE_WIDTH_RESET;
            count_reg <= '0;
            err_reg <= STATUS_OK;
            maxlen_reg <= '0;
            psum_reg <= '0;
            lines_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                lw_reg <= cfg_data;
            end
            count_reg <= count_next;
            err_reg <= err_next;
            maxlen_reg <= maxlen_next;
            psum_reg <= psum_next;
            lines_reg <= lines_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg <= j_next;
        i_reg <= i_next;
        pj_reg <= pj_next;
        cur_best_reg <= cur_best_next;
        cur_bp_reg <= cur_bp_next;
        b_reg <= b_next;
        total_reg <= total_next;
        spare_reg <= spare_next;
        prod_reg <= prod_next;
        fw_reg <= fw_next;
        lwi_reg <= lwi_next;
        ll_reg <= ll_next;
        st_reg <= st_next;
        tc_reg <= tc_next;
    end
endmodule

[rtl/wwmr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wwmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/wwmr_checker.sv]
// Port-level assertions of the word wrap block, bound to its top level.
module wwmr_assertions (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [5:0]  first_word,
    input logic [5:0]  last_word_index,
    input logic        last_line,
    input logic [1:0]  status,
    input logic [41:0] total_cost
);
    import wwmr_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(first_word) && $stable(total_cost))
        else $error("Stalled result transaction changed.");

    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> last_line && first_word == 6'd0 &&
        last_word_index == 6'd0 && total_cost == 42'd0)
        else $error("Error result transaction is malformed.");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_line ##1 out_valid |->
        first_word == 6'($past(last_word_index) + 6'd1) && total_cost == $past(total_cost))
        else $error("Consecutive line transactions are not contiguous.");
endmodule

bind word_wrap_min_raggedness wwmr_assertions u_wwmr_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .first_word(first_word), .last_word_index(last_word_index), .last_line(last_line),
    .status(status), .total_cost(total_cost)
);

[tb/wwmr_checker.sv]
// Checker that predicts the line breaks of each paragraph and compares every result transaction.
module wwmr_checker #(
    parameter int MAX_WORDS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  word_length,
    input  logic        last_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [5:0]  first_word,
    input  logic [5:0]  last_word_index,
    input  logic        last_line,
    input  logic [1:0]  status,
    input  logic [41:0] total_cost,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import wwmr_pkg::*;

    typedef struct {
        logic [5:0]  first;
        logic [5:0]  last;
        logic        fin;
        logic [1:0]  stat;
        logic [41:0] cost;
    } line_t;

    line_t       line_q[$];
    width_t      width_reg;
    logic [7:0]  len_mem[MAX_WORDS];
    logic [13:0] psum[MAX_WORDS+1];
    int          word_cnt;
    logic [1:0]  err_code;

    function automatic line_t make_line(int f, int l, bit fin, logic [1:0] st,
                                        logic [63:0] c);
        line_t r;
        r.first = f[5:0];
        r.last = l[5:0];
        r.fin = fin;
        r.stat = st;
        r.cost = c[41:0];
        return r;
    endfunction

    task automatic solve_paragraph();
        logic [63:0] best[MAX_WORDS+1];
        int          brk[MAX_WORDS+1];
        int          starts[$];
        int          used;
        int          j;
        logic [63:0] spare;
        logic [63:0] c;
        best[0] = 0;
        for (int jj = 1; jj <= word_cnt; jj++)
        begin
            best[jj] = {21'd0, COST_INF};
            brk[jj] = 0;
            for (int i = 1; i <= jj; i++)
            begin
                used = int'(psum[jj]) - int'(psum[i-1]) + (jj - i);
                if (used > int'(width_reg) || best[i-1] == {21'd0, COST_INF})
                    continue;
                spare = 64'(int'(width_reg) - used);
                c = (jj == word_cnt) ? 64'd0 : spare * spare * spare;
                if (best[i-1] + c < best[jj])
                begin
                    best[jj] = best[i-1] + c;
                    brk[jj] = i;
                end
            end
        end
        j = word_cnt;
        while (j > 0 && brk[j] >= 1)
        begin
            starts.push_front(j);
            j = brk[j] - 1;
        end
        foreach (starts[k])
            line_q.insert(line_q.size(), make_line(brk[starts[k]] - 1, starts[k] - 1,
                          starts[k] == word_cnt, STATUS_OK, best[word_cnt]));
    endtask

    task automatic predict_word(logic [7:0] len, logic fin);
        if (word_cnt < MAX_WORDS)
        begin
            len_mem[word_cnt] = len;
            psum[word_cnt+1] = psum[word_cnt] + len;
            word_cnt++;
        end
        else
            err_code = STATUS_OVERFLOW;
        if (fin)
        begin
            if (err_code == STATUS_OK)
                for (int k = 0; k < word_cnt; k++)
                    if (len_mem[k] > width_reg)
                        err_code = STATUS_WIDE;
            if (err_code != STATUS_OK)
                line_q.insert(line_q.size(), make_line(0, 0, 1'b1, err_code, 64'd0));
            else
                solve_paragraph();
            word_cnt = 0;
            err_code = STATUS_OK;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_t e;
        if (!rst_n)
        begin
            width_reg = LINE_WIDTH_RESET;
            psum[0] = 0;
            word_cnt = 0;
            err_code = STATUS_OK;
            errors = 0;
            line_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                width_reg = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (line_q.size() == 0)
                begin
                    $display("%0t: expected no result, actual first %0d last %0d",
                             $time, first_word, last_word_index);
                    errors++;
                end
                else
                begin
                    e = line_q.pop_front();
                    if (first_word !== e.first || last_word_index !== e.last ||
                        last_line !== e.fin || status !== e.stat || total_cost !== e.cost)
                    begin
                        $display("%0t: expected first %0d last %0d fin %0d status %0d cost %0d",
                                 $time, e.first, e.last, e.fin, e.stat, e.cost);
                        $display("%0t: actual   first %0d last %0d fin %0d status %0d cost %0d",
                                 $time, first_word, last_word_index, last_line, status,
                                 total_cost);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_word(word_length, last_word);
        end
        pending = line_q.size();
    end
endmodule

[tb/tb_word_wrap_min_raggedness.sv]
// Testbench top that drives paragraphs and line widths into the word wrap block.
module tb_word_wrap_min_raggedness;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 50000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [11:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  word_length = '0;
    logic        last_word = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  first_word;
    logic [5:0]  last_word_index;
    logic        last_line;
    logic [1:0]  status;
    logic [41:0] total_cost;
    int          errors;
    int          pending;
    int          items = 0;
    int          idle_cycles = 0;
    bit          hold_req = 1'b0;
    int          cur_width = 80;
    bit          quiet = 1'b0;
    bit          big_done = 1'b0;
    bit          over_done = 1'b0;

    always #2 clk = ~clk;

    word_wrap_min_raggedness u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .word_length(word_length), .last_word(last_word),
        .out_valid(out_valid), .out_stall(out_stall),
        .first_word(first_word), .last_word_index(last_word_index),
        .last_line(last_line), .status(status), .total_cost(total_cost)
    );

    wwmr_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .word_length(word_length), .last_word(last_word),
        .out_valid(out_valid), .out_stall(out_stall),
        .first_word(first_word), .last_word_index(last_word_index),
        .last_line(last_line), .status(status), .total_cost(total_cost),
        .errors(errors), .pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT)
        begin
            $display("word_wrap_min_raggedness: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            quiet <= ~quiet;
    end

    initial
    begin
        int left;
        int held;
        bit hold_used;
        left = 0;
        held = 0;
        hold_used = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_used)
            begin
                held = 600;
                hold_used = 1'b1;
            end
            if (held > 0)
            begin
                out_stall <= 1'b1;
                held--;
            end
            else if (left > 0)
            begin
                out_stall <= 1'b1;
                left--;
            end
            else
            begin
                left = gap_len();
                out_stall <= (left > 0);
                if (left > 0)
                    left--;
            end
        end
    end

    task automatic send_word(int len, bit fin);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        word_length <= len[7:0];
        last_word <= fin;
        do
            @(posedge clk);
        while (in_stall);
        items++;
    endtask

    task automatic finish_words();
        in_valid <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_width(int w);
        finish_words();
        cfg_valid <= 1'b1;
        cfg_data <= w[11:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_width = w;
    endtask

    task automatic send_random_paragraph();
        int n;
        int r;
        int top;
        r = $urandom_range(0, 99);
        if (r < 80)
            n = $urandom_range(1, 8);
        else if (r < 93)
            n = $urandom_range(9, 24);
        else if (!big_done && r < 97)
        begin
            n = 64;
            big_done = 1'b1;
        end
        else if (!over_done)
        begin
            n = $urandom_range(65, 67);
            over_done = 1'b1;
        end
        else
            n = $urandom_range(2, 6);
        top = (cur_width > 255) ? 255 : cur_width / 2;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < 88)
                send_word($urandom_range(0, top), k == n - 1);
            else
                send_word($urandom_range(0, 255), k == n - 1);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(0, 1'b1);
        send_word(5, 1'b0);
        send_word(255, 1'b1);
        send_word(30, 1'b0);
        send_word(40, 1'b0);
        send_word(9, 1'b1);
        write_width(4095);
        send_word(255, 1'b0);
        send_word(255, 1'b0);
        send_word(0, 1'b0);
        send_word(128, 1'b1);
        write_width(0);
        send_word(0, 1'b0);
        send_word(0, 1'b0);
        send_word(0, 1'b1);
        send_word(1, 1'b1);
        write_width(1);
        send_word(1, 1'b0);
        send_word(2, 1'b1);
        send_word(1, 1'b0);
        send_word(0, 1'b1);
        write_width(12);
        hold_req = 1'b1;
        send_word(3, 1'b0);
        send_word(4, 1'b0);
        send_word(2, 1'b0);
        send_word(5, 1'b1);
        send_word(6, 1'b1);

        while (items < 110)
        begin
            if ($urandom_range(0, 5) == 0)
                write_width(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095)
                                                        : $urandom_range(8, 120));
            send_random_paragraph();
        end

        finish_words();
        if (errors == 0)
            $display("word_wrap_min_raggedness: match");
        else
            $display("word_wrap_min_raggedness: mismatch");
        $finish;
    end
endmodule
